@@ src/sha256_message_digest_unit_defines.svh @@
// Assertion macros used by the digest unit top-level RTL file
`ifndef SHA256_MESSAGE_DIGEST_UNIT_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk, quiet while rst is high
`define SMD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smd: same-cycle check failed");

// Next-cycle implication, checked on clk, quiet while rst is high
`define SMD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smd: next-cycle check failed");

`endif

@@ src/smd_pkg.sv @@
// Shared types, constant tables and round functions of the SHA-256 unit
`default_nettype none

package smd_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       has_byte;
    logic       end_of_message;
  } smd_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } smd_out_t;

  // Top-level sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_DREAD,
    ST_DLOAD
  } smd_state_t;

  // Compression engine states
  typedef enum logic [1:0] {
    CMP_IDLE,
    CMP_LOAD,
    CMP_ROUND,
    CMP_ADD
  } cmp_state_t;

  // Port requests and status of the compression engine
  typedef struct packed {
    logic       busy;
    logic       done;
    logic [2:0] chain_raddr;
    logic       chain_we;
    logic [2:0] chain_waddr;
    word_t      chain_wdata;
    logic [3:0] block_raddr;
  } smd_cmp_port_t;

  localparam int unsigned CHAIN_DEPTH = 8;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam logic [5:0]  FILL_LAST   = 6'd63;
  localparam logic [5:0]  LEN_POS     = 6'd56;
  localparam logic [5:0]  ROUND_LAST  = 6'd63;
  localparam logic [5:0]  SWEEP_LAST  = 6'd8;
  localparam logic [2:0]  WORD_LAST   = 3'd7;
  localparam logic [7:0]  PAD_MARK    = 8'h80;
  localparam logic [63:0] BYTE_BITS   = 64'd8;

  localparam word_t SMD_IV [CHAIN_DEPTH] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t SMD_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sig0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sig0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

@@ src/smd_ram.sv @@
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module smd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry into the registered read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/smd_compress.sv @@
// SHA-256 compression engine: chain load, 64 rounds, chain add-back
`default_nettype none

module smd_compress (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  smd_pkg::word_t        chain_rdata,
  input  smd_pkg::word_t        block_rdata,
  output smd_pkg::smd_cmp_port_t port
);

  import smd_pkg::*;

  cmp_state_t state, state_next;
  logic [5:0] cnt, cnt_next;
  word_t      v [8];
  word_t      sched [BLOCK_WORDS];
  word_t      w_t;
  word_t      t1;
  word_t      t2;

  // Schedule word and round sums
  always_comb begin
    if (cnt[5:4] == 2'b00) begin
      w_t = block_rdata;
    end else begin
      w_t = sched[0] + small_sig0(sched[1]) + sched[9] + small_sig1(sched[14]);
    end
    t1 = v[7] + big_sig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SMD_K[cnt] + w_t;
    t2 = big_sig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // Sequence the sweeps and drive the memory ports
  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    port             = '0;
    port.busy        = (state != CMP_IDLE);
    port.chain_raddr = cnt[2:0];
    port.chain_waddr = cnt[2:0] - 3'd1;
    port.chain_wdata = chain_rdata + v[0];
    port.block_raddr = cnt[3:0] + 4'd1;
    case (state)
      CMP_IDLE: begin
        if (start) begin
          state_next = CMP_LOAD;
          cnt_next   = '0;
        end
      end
      CMP_LOAD: begin
        port.block_raddr = '0;
        if (cnt == SWEEP_LAST) begin
          state_next = CMP_ROUND;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      CMP_ROUND: begin
        if (cnt == ROUND_LAST) begin
          state_next = CMP_ADD;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      CMP_ADD: begin
        port.chain_we = (cnt != 6'd0);
        if (cnt == SWEEP_LAST) begin
          port.done  = 1'b1;
          state_next = CMP_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      default: begin
        state_next = CMP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CMP_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Working variables and message schedule window
  always_ff @(posedge clk) begin
    if ((state == CMP_LOAD || state == CMP_ADD) && cnt != 6'd0) begin
      for (int i = 0; i < 7; i++) begin
        v[i] <= v[i+1];
      end
      v[7] <= chain_rdata;
    end else if (state == CMP_ROUND) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[BLOCK_WORDS-1] <= w_t;
    end
  end

endmodule

`default_nettype wire

@@ src/sha256_message_digest_unit.sv @@
// SHA-256 over a byte stream: byte packing, padding, digest readout
//
// Input channel msg (valid/ready): one word carries at most one message
// byte; end_of_message closes the message, and a word with no byte and no
// end is dropped. Output channel dig (valid/ready): eight digest words,
// h0 first, the eighth marked last_word.
// Bytes are taken one per cycle while the sequencer is idle. Every 64th
// byte holds the input while the block is compressed (chain load from
// the chain RAM, 64 rounds one per cycle, add-back). After the closing
// word the padding bytes go through the same packer, one per cycle (up
// to 72 bytes, with one or two compressions); each digest word then
// takes one chain RAM read and one load into the output register. The
// next message is accepted as soon as the eighth digest word sits in
// the output register.
// Reset clears the sequencer, counters and chain valid bits, so the chain
// reads as the initial hash value; no clearing sweep is needed. A stalled
// receiver holds the current digest word and the readout waits for it.
`default_nettype none

`include "sha256_message_digest_unit_defines.svh"

module sha256_message_digest_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              msg_valid,
  output logic              msg_ready,
  input  smd_pkg::smd_in_t  msg,
  output logic              dig_valid,
  input  logic              dig_ready,
  output smd_pkg::smd_out_t dig
);

  import smd_pkg::*;

  smd_state_t    state, state_next;
  smd_state_t    after_comp;
  smd_cmp_port_t cmp;
  logic          cmp_start;
  logic          msg_accept;
  logic          dig_free;
  logic [5:0]    fill;
  logic [63:0]   bit_length;
  logic [23:0]   acc;
  logic          mark_done;
  logic          len_ok;
  logic [2:0]    dig_idx;
  logic          push;
  logic [7:0]    push_byte;
  logic [7:0]    pad_byte;
  logic [CHAIN_DEPTH-1:0] chain_valid;
  logic [2:0]    chain_raddr;
  logic [2:0]    chain_raddr_q;
  logic          chain_rvalid_q;
  word_t         chain_rdata;
  word_t         chain_word;
  word_t         block_rdata;
  logic          block_we;

  assign msg_ready  = (state == ST_IDLE);
  assign msg_accept = msg_valid && msg_ready;
  assign dig_free   = !dig_valid || dig_ready;

  // Padding byte: marker first, zeros, then big-endian length in the last block
  always_comb begin
    if (!mark_done) begin
      pad_byte = PAD_MARK;
    end else if (len_ok && fill[5:3] == LEN_POS[5:3]) begin
      pad_byte = bit_length[{~fill[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Sequencer: next state, byte push and compression start
  always_comb begin
    state_next = state;
    cmp_start  = 1'b0;
    push       = 1'b0;
    push_byte  = msg.message_byte;
    case (state)
      ST_IDLE: begin
        if (msg_accept) begin
          push = msg.has_byte;
          if (msg.has_byte && fill == FILL_LAST) begin
            cmp_start  = 1'b1;
            state_next = ST_COMP;
          end else if (msg.end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push      = 1'b1;
        push_byte = pad_byte;
        if (fill == FILL_LAST) begin
          cmp_start  = 1'b1;
          state_next = ST_COMP;
        end
      end
      ST_COMP: begin
        if (cmp.done) begin
          state_next = after_comp;
        end
      end
      ST_DREAD: begin
        if (dig_free) begin
          state_next = ST_DLOAD;
        end
      end
      ST_DLOAD: begin
        state_next = (dig_idx == WORD_LAST) ? ST_IDLE : ST_DREAD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      after_comp  <= ST_IDLE;
      fill        <= '0;
      bit_length  <= '0;
      mark_done   <= 1'b0;
      len_ok      <= 1'b0;
      dig_idx     <= '0;
      chain_valid <= '0;
      dig_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (push) begin
        fill <= fill + 6'd1;
      end
      if (state == ST_IDLE && msg_accept) begin
        if (msg.has_byte) begin
          bit_length <= bit_length + BYTE_BITS;
        end
        mark_done  <= 1'b0;
        len_ok     <= 1'b0;
        after_comp <= msg.end_of_message ? ST_PAD : ST_IDLE;
      end
      if (state == ST_PAD) begin
        mark_done <= 1'b1;
        if (!mark_done && fill < LEN_POS) begin
          len_ok <= 1'b1;
        end
        if (fill == FILL_LAST) begin
          after_comp <= len_ok ? ST_DREAD : ST_PAD;
          len_ok     <= 1'b1;
          dig_idx    <= '0;
        end
      end
      if (cmp.chain_we) begin
        chain_valid[cmp.chain_waddr] <= 1'b1;
      end
      // Return to the initial hash once the last digest word is loaded
      if (state == ST_DLOAD) begin
        dig_idx <= dig_idx + 3'd1;
        if (dig_idx == WORD_LAST) begin
          bit_length  <= '0;
          chain_valid <= '0;
        end
      end
      if (state == ST_DLOAD) begin
        dig_valid <= 1'b1;
      end else if (dig_ready) begin
        dig_valid <= 1'b0;
      end
    end
  end

  // Payload registers: byte packer and digest output word
  always_ff @(posedge clk) begin
    if (push) begin
      acc <= {acc[15:0], push_byte};
    end
    chain_raddr_q  <= chain_raddr;
    chain_rvalid_q <= chain_valid[chain_raddr];
    if (state == ST_DLOAD) begin
      dig <= '{digest_word: chain_word,
               word_index:  dig_idx,
               last_word:   (dig_idx == WORD_LAST)};
    end
  end

  // Write a block word on every fourth byte
  assign block_we    = push && (fill[1:0] == 2'b11);
  assign chain_raddr = (state == ST_COMP) ? cmp.chain_raddr : dig_idx;
  assign chain_word  = chain_rvalid_q ? chain_rdata : SMD_IV[chain_raddr_q];

  smd_ram #(
    .WIDTH (32),
    .DEPTH (BLOCK_WORDS)
  ) u_block_ram (
    .clk   (clk),
    .we    (block_we),
    .waddr (fill[5:2]),
    .wdata ({acc, push_byte}),
    .raddr (cmp.block_raddr),
    .rdata (block_rdata)
  );

  smd_ram #(
    .WIDTH (32),
    .DEPTH (CHAIN_DEPTH)
  ) u_chain_ram (
    .clk   (clk),
    .we    (cmp.chain_we),
    .waddr (cmp.chain_waddr),
    .wdata (cmp.chain_wdata),
    .raddr (chain_raddr),
    .rdata (chain_rdata)
  );

  smd_compress u_compress (
    .clk         (clk),
    .rst         (rst),
    .start       (cmp_start),
    .chain_rdata (chain_word),
    .block_rdata (block_rdata),
    .port        (cmp)
  );

  // Checks on sequencing between packer, engine and readout
  `SMD_ASSERT_IMP(a_ready_engine_idle, msg_ready, !cmp.busy)
  `SMD_ASSERT_IMP(a_chain_write_in_comp, cmp.chain_we, state == ST_COMP)
  `SMD_ASSERT_NXT(a_start_busy, cmp_start, cmp.busy)
  `SMD_ASSERT_IMP(a_load_slot_free, state == ST_DLOAD, !dig_valid)
  `SMD_ASSERT_IMP(a_last_index, dig_valid && dig.last_word, dig.word_index == WORD_LAST)

endmodule

`default_nettype wire

@@ verif/sha256_message_digest_unit_tb.sv @@
// Self-checking testbench for the SHA-256 message digest unit
`timescale 1ns / 100ps

module sha256_message_digest_unit_tb;
  import smd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned HOLD_AT      = 30;
  localparam int unsigned HOLD_LEN     = 600;
  localparam int unsigned PHASE_WORDS  = 25;
  localparam int unsigned PRINT_CAP    = 30;
  localparam int unsigned PAD_BYTE     = 8'h80;
  localparam int unsigned LEN_OFFSET   = 56;
  localparam int SEND_IDLE [4]  = '{0, 49, 0, 35};
  localparam int RECV_STALL [4] = '{0, 0, 49, 35};

  localparam logic [31:0] IV_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     msg_valid = 1'b0;
  logic     msg_ready;
  smd_in_t  msg = '0;
  logic     dig_valid;
  logic     dig_ready = 1'b0;
  smd_out_t dig;

  // Hash predictor state
  logic [31:0] hash_state [8];
  logic [7:0]  blk_buf [64];
  int unsigned blk_fill;
  logic [63:0] msg_bits;

  smd_in_t  pending_q [$];
  smd_out_t digest_q [$];
  smd_out_t want;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned words_taken = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned err_count = 0;
  int unsigned digests_checked = 0;
  int unsigned queued_items = 0;
  int unsigned messages_sent = 0;
  int unsigned bytes_sent = 0;

  sha256_message_digest_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig       (dig)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Compress the block buffer into the running hash
  function automatic void sha_compress();
    logic [31:0] sched [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      sched[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
    end
    v = hash_state;
    for (int i = 0; i < 64; i++) begin
      s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
      t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_K[i] + sched[i];
      s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
      t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++)
      hash_state[i] = hash_state[i] + v[i];
  endfunction

  // Absorb one accepted word; on a closing word pad, finish and queue the digest
  function automatic void take_word(smd_in_t w);
    smd_out_t d;
    if (w.has_byte) begin
      blk_buf[blk_fill] = w.message_byte;
      msg_bits = msg_bits + 64'd8;
      blk_fill++;
      if (blk_fill == 64) begin
        sha_compress();
        blk_fill = 0;
      end
    end
    if (w.end_of_message) begin
      blk_buf[blk_fill] = PAD_BYTE[7:0];
      blk_fill++;
      // no room for the length: close this block and open another
      if (blk_fill > LEN_OFFSET) begin
        while (blk_fill < 64) begin
          blk_buf[blk_fill] = 8'h00;
          blk_fill++;
        end
        sha_compress();
        blk_fill = 0;
      end
      while (blk_fill < LEN_OFFSET) begin
        blk_buf[blk_fill] = 8'h00;
        blk_fill++;
      end
      for (int i = 0; i < 8; i++)
        blk_buf[LEN_OFFSET + i] = msg_bits[63 - 8*i -: 8];
      sha_compress();
      for (int i = 0; i < 8; i++) begin
        d.digest_word = hash_state[i];
        d.word_index  = 3'(i);
        d.last_word   = (i == 7);
        digest_q = {digest_q, d};
      end
      hash_state = IV_WORDS;
      blk_fill   = 0;
      msg_bits   = '0;
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    if (err_count < PRINT_CAP)
      $display("%0t ns: digest mismatch, %s: got %h, want %h", $time, what, got, exp_val);
    err_count++;
  endtask

  task automatic push_word(logic [7:0] b, logic has, logic eom);
    smd_in_t w;
    w.message_byte   = b;
    w.has_byte       = has;
    w.end_of_message = eom;
    pending_q = {pending_q, w};
    if (has || eom)
      queued_items++;
    if (has)
      bytes_sent++;
    if (eom)
      messages_sent++;
  endtask

  // Queue one message of random bytes, closed on its last byte or by an empty word
  task automatic queue_message(int unsigned n_bytes, logic end_on_byte);
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(99) < 4)
        push_word(8'($urandom_range(255)), 1'b0, 1'b0);
      push_word(8'($urandom_range(255)), 1'b1, end_on_byte && (i == n_bytes - 1));
    end
    if (!end_on_byte || n_bytes == 0)
      push_word(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // Drive the input channel and run the predictor on every accepted word
  always @(posedge clk) begin
    if (rst) begin
      msg_valid   <= 1'b0;
      msg         <= '0;
      words_taken <= 0;
      hash_state   = IV_WORDS;
      blk_fill     = 0;
      msg_bits     = '0;
      digest_q.delete();
    end else begin
      if (msg_valid && msg_ready) begin
        take_word(msg);
        words_taken <= words_taken + 1;
      end
      if (!msg_valid || msg_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          msg       <= pending_q.pop_front();
          msg_valid <= 1'b1;
        end else begin
          msg_valid <= 1'b0;
        end
      end
    end
  end

  // Drive the output ready; hold it off once for a long stretch
  always @(posedge clk) begin
    if (rst) begin
      dig_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_taken >= HOLD_AT) begin
      dig_ready <= 1'b0;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      dig_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      dig_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every digest word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && dig_valid && dig_ready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("word with nothing expected", dig.digest_word, '0);
      end else begin
        want = digest_q.pop_front();
        if (dig.digest_word !== want.digest_word)
          report_mismatch("digest_word", dig.digest_word, want.digest_word);
        if (dig.word_index !== want.word_index)
          report_mismatch("word_index", 32'(dig.word_index), 32'(want.word_index));
        if (dig.last_word !== want.last_word)
          report_mismatch("last_word", 32'(dig.last_word), 32'(want.last_word));
      end
      digests_checked++;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles, %0d digest words outstanding",
               $time, cycle_count, digest_q.size());
      $display("sha256_message_digest_unit_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned n_len;
    int unsigned pick;
    int unsigned target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ignored words, empty message, single extreme bytes, "abc", late close
    push_word(8'hff, 1'b0, 1'b0);
    push_word(8'h00, 1'b0, 1'b0);
    push_word(8'ha5, 1'b0, 1'b1);
    push_word(8'h00, 1'b1, 1'b1);
    push_word(8'hff, 1'b1, 1'b1);
    push_word(8'h61, 1'b1, 1'b0);
    push_word(8'h62, 1'b1, 1'b0);
    push_word(8'h63, 1'b1, 1'b1);
    push_word(8'h5a, 1'b1, 1'b0);
    push_word(8'h7e, 1'b0, 1'b0);
    push_word(8'h3c, 1'b0, 1'b1);

    // padding boundaries: length fits, length spills, full block then empty close
    queue_message(55, 1'b1);
    queue_message(56, 1'b1);
    queue_message(64, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      idle_pct  = SEND_IDLE[ph];
      stall_pct = RECV_STALL[ph];
      target    = queued_items + PHASE_WORDS;
      while (queued_items < target) begin
        pick = $urandom_range(99);
        if (pick < 60)
          n_len = $urandom_range(12);
        else if (pick < 80)
          n_len = $urandom_range(70, 13);
        else if (pick < 95)
          n_len = 55 + $urandom_range(1) + 8 * $urandom_range(1) + $urandom_range(1);
        else
          n_len = $urandom_range(130, 100);
        queue_message(n_len, $urandom_range(1));
      end
      while (pending_q.size() != 0)
        @(negedge clk);
    end

    // drain: all words in, all digests out, then watch for strays
    while (msg_valid || pending_q.size() != 0)
      @(negedge clk);
    while (digest_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Hashed %0d messages (%0d bytes, empty and block-boundary lengths included),",
             messages_sent, bytes_sent);
    $display("checked %0d digest words under four idle/stall mixes and one long output hold.",
             digests_checked);
    if (err_count == 0)
      $display("sha256_message_digest_unit_tb: done, clean");
    else
      $display("sha256_message_digest_unit_tb: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/smd_pkg.sv
src/smd_ram.sv
src/smd_compress.sv
src/sha256_message_digest_unit.sv
verif/sha256_message_digest_unit_tb.sv
